FILE: rtl/lfu_pkg.sv
package lfu_pkg;

   localparam int CAP_W  = 5;
   localparam int DATA_W = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } lfu_req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } lfu_rsp_type;

   // entry store write command
   typedef struct packed {
      logic fill;   // rewrite the whole entry, marks it valid
      logic dec;    // recency rank minus one
   } lfu_wr_type;

endpackage

FILE: rtl/lfu_cache_policy.sv
// channel   direction  payload                       transfer
// req       in         lfu_req_type (type, key, val)  req_valid & req_ready
// rsp       out        lfu_rsp_type (hit, value)      rsp_valid & rsp_ready
// csr       in         capacity, 5 bits               csr_valid & csr_ready
//
// A request walks the entry store one entry per cycle: a first pass finds the key, a
// free slot and the eviction victim, then, when an entry changes, a second pass
// rewrites it and shifts recency ranks.
// Reset clears the valid bits; capacity returns to 16.
// req_ready is low while a request is in work; the result register lets the next
// request in while a result still waits on rsp_ready.
module lfu_cache_policy #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 32,
   parameter int COUNT_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lfu_pkg::lfu_req_type        req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lfu_pkg::lfu_rsp_type        rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lfu_pkg::CAP_W-1:0]   csr_data
);
   import lfu_pkg::*;

   localparam int KW = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int UW = $clog2(MAX_ENTRIES + 1);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lfu_rsp_type      rsp_ff, rsp_in;

   logic              req_fire;
   logic [UW-1:0]     eff_cap;
   logic [31:0]       cap_wide;
   logic              out_free;
   logic              done;
   lfu_rsp_type       seq_rsp;
   logic [IW-1:0]     st_idx;
   lfu_wr_type        st_cmd;
   logic [KW-1:0]     st_wr_key;
   logic [DATA_W-1:0] st_wr_value;
   logic [COUNT_BITS-1:0] st_wr_count;
   logic [IW-1:0]     st_wr_rank;
   logic              st_rd_valid;
   logic [KW-1:0]     st_rd_key;
   logic [DATA_W-1:0] st_rd_value;
   logic [COUNT_BITS-1:0] st_rd_count;
   logic [IW-1:0]     st_rd_rank;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;
   assign cap_wide  = 32'(cap_ff);
   assign eff_cap   = (cap_wide > 32'(MAX_ENTRIES)) ? UW'(MAX_ENTRIES) : UW'(cap_wide);

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid_in = done ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_in       = done ? seq_rsp : rsp_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   lfu_seq #(
      .N  (MAX_ENTRIES),
      .KW (KW),
      .CW (COUNT_BITS),
      .IW (IW),
      .UW (UW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .req_ready   (req_ready),
      .eff_cap     (eff_cap),
      .out_free    (out_free),
      .done        (done),
      .rsp         (seq_rsp),
      .st_idx      (st_idx),
      .st_cmd      (st_cmd),
      .st_wr_key   (st_wr_key),
      .st_wr_value (st_wr_value),
      .st_wr_count (st_wr_count),
      .st_wr_rank  (st_wr_rank),
      .st_rd_valid (st_rd_valid),
      .st_rd_key   (st_rd_key),
      .st_rd_value (st_rd_value),
      .st_rd_count (st_rd_count),
      .st_rd_rank  (st_rd_rank)
   );

   lfu_store #(
      .N  (MAX_ENTRIES),
      .KW (KW),
      .CW (COUNT_BITS),
      .IW (IW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .idx      (st_idx),
      .cmd      (st_cmd),
      .wr_key   (st_wr_key),
      .wr_value (st_wr_value),
      .wr_count (st_wr_count),
      .wr_rank  (st_wr_rank),
      .rd_valid (st_rd_valid),
      .rd_key   (st_rd_key),
      .rd_value (st_rd_value),
      .rd_count (st_rd_count),
      .rd_rank  (st_rd_rank)
   );

endmodule

FILE: rtl/lfu_store.sv
module lfu_store #(
   parameter int N  = 16,
   parameter int KW = 32,
   parameter int CW = 16,
   parameter int IW = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [IW-1:0]               idx,
   input  lfu_pkg::lfu_wr_type         cmd,
   input  logic [KW-1:0]               wr_key,
   input  logic [lfu_pkg::DATA_W-1:0]  wr_value,
   input  logic [CW-1:0]               wr_count,
   input  logic [IW-1:0]               wr_rank,
   output logic                        rd_valid,
   output logic [KW-1:0]               rd_key,
   output logic [lfu_pkg::DATA_W-1:0]  rd_value,
   output logic [CW-1:0]               rd_count,
   output logic [IW-1:0]               rd_rank
);
   import lfu_pkg::*;

   logic              valid_ff [N];
   logic [KW-1:0]     key_ff   [N];
   logic [DATA_W-1:0] value_ff [N];
   logic [CW-1:0]     count_ff [N];
   logic [IW-1:0]     rank_ff  [N];

   assign rd_valid = valid_ff[idx];
   assign rd_key   = key_ff[idx];
   assign rd_value = value_ff[idx];
   assign rd_count = count_ff[idx];
   assign rd_rank  = rank_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.fill) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         key_ff[idx]   <= wr_key;
         value_ff[idx] <= wr_value;
         count_ff[idx] <= wr_count;
         rank_ff[idx]  <= wr_rank;
      end else if (cmd.dec) begin
         rank_ff[idx]  <= rank_ff[idx] - IW'(1);
      end
   end

endmodule

FILE: rtl/lfu_seq.sv
module lfu_seq #(
   parameter int N  = 16,
   parameter int KW = 32,
   parameter int CW = 16,
   parameter int IW = 4,
   parameter int UW = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_fire,
   input  lfu_pkg::lfu_req_type        req_payload,
   output logic                        req_ready,
   input  logic [UW-1:0]               eff_cap,
   input  logic                        out_free,
   output logic                        done,
   output lfu_pkg::lfu_rsp_type        rsp,
   output logic [IW-1:0]               st_idx,
   output lfu_pkg::lfu_wr_type         st_cmd,
   output logic [KW-1:0]               st_wr_key,
   output logic [lfu_pkg::DATA_W-1:0]  st_wr_value,
   output logic [CW-1:0]               st_wr_count,
   output logic [IW-1:0]               st_wr_rank,
   input  logic                        st_rd_valid,
   input  logic [KW-1:0]               st_rd_key,
   input  logic [lfu_pkg::DATA_W-1:0]  st_rd_value,
   input  logic [CW-1:0]               st_rd_count,
   input  logic [IW-1:0]               st_rd_rank
);
   import lfu_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_UPD    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
   localparam logic [IW-1:0] IDX_LAST  = IW'(N - 1);

   state_type         state_ff, state_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [UW-1:0]     used_ff, used_in;
   logic              is_put_ff, is_put_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     slot_ff, slot_in;
   logic [IW-1:0]     slot_rank_ff, slot_rank_in;
   logic [CW-1:0]     slot_count_ff, slot_count_in;
   logic [DATA_W-1:0] slot_value_ff, slot_value_in;
   logic              free_found_ff, free_found_in;
   logic [IW-1:0]     free_ff, free_in;
   logic              vic_any_ff, vic_any_in;
   logic [IW-1:0]     vic_ff, vic_in;
   logic [CW-1:0]     vic_count_ff, vic_count_in;
   logic [IW-1:0]     vic_rank_ff, vic_rank_in;
   logic [IW-1:0]     tgt_ff, tgt_in;
   logic              close_ff, close_in;
   logic [IW-1:0]     close_rank_ff, close_rank_in;
   logic [IW-1:0]     new_rank_ff, new_rank_in;
   logic [CW-1:0]     new_count_ff, new_count_in;
   logic [DATA_W-1:0] new_value_ff, new_value_in;

   logic          last;
   logic          match;
   logic          vic_better;
   logic          touch;
   logic [CW-1:0] inc_count;
   logic [IW-1:0] top_rank;

   assign last       = (idx_ff == IDX_LAST);
   assign match      = st_rd_valid && (st_rd_key == key_ff);
   assign vic_better = st_rd_valid && (!vic_any_ff || (st_rd_count < vic_count_ff) ||
                       ((st_rd_count == vic_count_ff) && (st_rd_rank < vic_rank_ff)));
   assign inc_count  = (slot_count_ff == COUNT_MAX) ? slot_count_ff
                                                    : slot_count_ff + CW'(1);
   assign top_rank   = IW'(used_ff - UW'(1));
   assign touch      = found_ff && (!is_put_ff || (eff_cap != '0));

   assign req_ready   = (state_ff == ST_IDLE);
   assign st_idx      = idx_ff;
   assign st_wr_key   = key_ff;
   assign st_wr_value = new_value_ff;
   assign st_wr_count = new_count_ff;
   assign st_wr_rank  = new_rank_ff;

   assign rsp.hit        = found_ff;
   assign rsp.read_value = (!is_put_ff && found_ff) ? slot_value_ff : MISS_VALUE;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      is_put_in     = is_put_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      slot_rank_in  = slot_rank_ff;
      slot_count_in = slot_count_ff;
      slot_value_in = slot_value_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      vic_any_in    = vic_any_ff;
      vic_in        = vic_ff;
      vic_count_in  = vic_count_ff;
      vic_rank_in   = vic_rank_ff;
      tgt_in        = tgt_ff;
      close_in      = close_ff;
      close_rank_in = close_rank_ff;
      new_rank_in   = new_rank_ff;
      new_count_in  = new_count_ff;
      new_value_in  = new_value_ff;
      st_cmd        = '0;
      done          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in      = ST_SCAN;
               idx_in        = '0;
               is_put_in     = (req_payload.req_type == REQ_PUT);
               key_in        = req_payload.key[KW-1:0];
               value_in      = req_payload.value;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               vic_any_in    = 1'b0;
            end
         end
         ST_SCAN: begin
            if (match && !found_ff) begin
               found_in      = 1'b1;
               slot_in       = idx_ff;
               slot_rank_in  = st_rd_rank;
               slot_count_in = st_rd_count;
               slot_value_in = st_rd_value;
            end
            if (!st_rd_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_in       = idx_ff;
            end
            if (vic_better) begin
               vic_any_in   = 1'b1;
               vic_in       = idx_ff;
               vic_count_in = st_rd_count;
               vic_rank_in  = st_rd_rank;
            end
            idx_in = idx_ff + IW'(1);
            if (last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            idx_in   = '0;
            state_in = ST_DONE;
            if (touch) begin
               state_in      = ST_UPD;
               tgt_in        = slot_ff;
               close_in      = 1'b1;
               close_rank_in = slot_rank_ff;
               new_rank_in   = top_rank;
               new_count_in  = inc_count;
               new_value_in  = is_put_ff ? value_ff : slot_value_ff;
            end else if (is_put_ff && !found_ff && (eff_cap != '0)) begin
               new_count_in = CW'(1);
               new_value_in = value_ff;
               if ((used_ff < eff_cap) && free_found_ff) begin
                  state_in    = ST_UPD;
                  tgt_in      = free_ff;
                  close_in    = 1'b0;
                  new_rank_in = IW'(used_ff);
                  used_in     = used_ff + UW'(1);
               end else if (vic_any_ff) begin
                  state_in      = ST_UPD;
                  tgt_in        = vic_ff;
                  close_in      = 1'b1;
                  close_rank_in = vic_rank_ff;
                  new_rank_in   = top_rank;
               end
            end
         end
         ST_UPD: begin
            if (idx_ff == tgt_ff) begin
               st_cmd.fill = 1'b1;
            end else if (st_rd_valid && close_ff && (st_rd_rank > close_rank_ff)) begin
               st_cmd.dec = 1'b1;
            end
            idx_in = idx_ff + IW'(1);
            if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      is_put_ff     <= is_put_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      slot_rank_ff  <= slot_rank_in;
      slot_count_ff <= slot_count_in;
      slot_value_ff <= slot_value_in;
      free_found_ff <= free_found_in;
      free_ff       <= free_in;
      vic_any_ff    <= vic_any_in;
      vic_ff        <= vic_in;
      vic_count_ff  <= vic_count_in;
      vic_rank_ff   <= vic_rank_in;
      tgt_ff        <= tgt_in;
      close_ff      <= close_in;
      close_rank_ff <= close_rank_in;
      new_rank_ff   <= new_rank_in;
      new_count_ff  <= new_count_in;
      new_value_ff  <= new_value_in;
   end

endmodule
